>>> rtl/dale_pkg.sv
package dale_pkg;

   localparam int BIN_WIDTH     = 32;
   localparam int DABBLE_STEPS  = 8;
   localparam int DABBLE_STAGES = BIN_WIDTH / DABBLE_STEPS;

   localparam logic [1:0] PREFIX_NONE     = 2'd0;
   localparam logic [1:0] PREFIX_MINUS    = 2'd1;
   localparam logic [1:0] PREFIX_LETTER_C = 2'd2;

   localparam logic [7:0] ASCII_MINUS  = 8'h2d;
   localparam logic [7:0] ASCII_C      = 8'h43;
   localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
   localparam logic [7:0] ASCII_CR     = 8'h0d;
   localparam logic [7:0] ASCII_LF     = 8'h0a;

   typedef struct packed {
      logic [1:0]           prefix;
      logic [BIN_WIDTH-1:0] bin;
   } dale_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFIX,
      ST_DIGIT,
      ST_CR,
      ST_LF
   } dale_state_type;

endpackage

>>> rtl/dale_bcd_stage.sv
module dale_bcd_stage #(
   parameter int DIGIT_COUNT = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  dale_pkg::dale_word_type     in_word,
   input  logic [4*DIGIT_COUNT-1:0]    in_bcd,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dale_pkg::dale_word_type     out_word,
   output logic [4*DIGIT_COUNT-1:0]    out_bcd
);
   import dale_pkg::*;

   localparam int BCD_WIDTH = 4 * DIGIT_COUNT;

   logic                 valid_ff;
   dale_word_type        word_ff;
   logic [BCD_WIDTH-1:0] bcd_ff;
   dale_word_type        word_in;
   logic [BCD_WIDTH-1:0] bcd_in;

   // Each step adds three to every digit of five or more, then shifts one bit in.
   always_comb begin
      word_in = in_word;
      bcd_in  = in_bcd;
      for (int s = 0; s < DABBLE_STEPS; s++) begin
         for (int d = 0; d < DIGIT_COUNT; d++) begin
            if (bcd_in[4*d +: 4] >= 4'd5) begin
               bcd_in[4*d +: 4] = bcd_in[4*d +: 4] + 4'd3;
            end
         end
         bcd_in      = {bcd_in[BCD_WIDTH-2:0], word_in.bin[BIN_WIDTH-1]};
         word_in.bin = {word_in.bin[BIN_WIDTH-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
         bcd_ff  <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_bcd   = bcd_ff;

endmodule

>>> rtl/dale_serializer.sv
module dale_serializer #(
   parameter int DIGIT_COUNT = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [1:0]                  in_prefix,
   input  logic [4*DIGIT_COUNT-1:0]    in_bcd,
   input  logic                        crlf,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);
   import dale_pkg::*;

   localparam int IDX_W = $clog2(DIGIT_COUNT);

   dale_state_type   state_ff;
   dale_state_type   state_in;
   logic [IDX_W-1:0] ptr_ff;
   logic [IDX_W-1:0] ptr_in;
   logic [IDX_W-1:0] top_digit;
   logic [3:0]       digits_ff [DIGIT_COUNT];
   logic [1:0]       prefix_ff;
   logic             crlf_item_ff;
   logic             rsp_tvalid_ff;
   logic [7:0]       rsp_tdata_ff;
   logic             rsp_tlast_ff;
   logic             out_free;
   logic             load_out;
   logic [7:0]       out_byte;
   logic             out_last;

   always_comb begin
      top_digit = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (in_bcd[4*i +: 4] != 4'd0) begin
            top_digit = IDX_W'(i);
         end
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      load_out = 1'b0;
      out_byte = '0;
      out_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               ptr_in = top_digit;
               if (in_prefix inside {PREFIX_MINUS, PREFIX_LETTER_C}) begin
                  state_in = ST_PREFIX;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_PREFIX: begin
            if (out_free) begin
               load_out = 1'b1;
               out_byte = (prefix_ff == PREFIX_MINUS) ? ASCII_MINUS : ASCII_C;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               load_out = 1'b1;
               out_byte = {ASCII_DIGIT_HI, digits_ff[ptr_ff]};
               if (ptr_ff == '0) begin
                  if (crlf_item_ff) begin
                     state_in = ST_CR;
                  end else begin
                     out_last = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  ptr_in = ptr_ff - IDX_W'(1);
               end
            end
         end
         ST_CR: begin
            if (out_free) begin
               load_out = 1'b1;
               out_byte = ASCII_CR;
               state_in = ST_LF;
            end
         end
         ST_LF: begin
            if (out_free) begin
               load_out = 1'b1;
               out_byte = ASCII_LF;
               out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_free) begin
            rsp_tvalid_ff <= load_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (in_valid && in_ready) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digits_ff[i] <= in_bcd[4*i +: 4];
         end
         prefix_ff    <= in_prefix;
         crlf_item_ff <= crlf;
      end
      if (load_out) begin
         rsp_tdata_ff <= out_byte;
         rsp_tlast_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

>>> rtl/decimal_ascii_line_emitter.sv
// Prints an unsigned 32-bit number as a line of ASCII decimal text.
// Each transfer on the req_ channel carries the number in req_tdata and a
// prefix selector in req_tuser (none, minus sign, letter C, or none again).
// The rsp_ channel gives one byte per transfer: the prefix, the digits with
// the most significant first and no leading zeros, and CR and LF when the
// csr_ register is set; rsp_tlast marks the final byte of each line.
// The csr_ register must be written only while no line is in flight;
// the block itself does not enforce it. A number passes the four conversion
// stages, then the serializer state register and the output register.
// The byte serializer sends a line byte by byte, holding while rsp_tready is
// low, and takes the next number only after a line's last byte; meanwhile the
// binary to decimal pipeline's four stages hold up to four further numbers.
// When the receiver stalls, the current byte is held and the pipeline fills,
// then req_tready falls; nothing is lost or repeated.
// Reset empties the pipeline and the output register and sets the CR/LF
// register to one.
module decimal_ascii_line_emitter #(
   parameter int DIGIT_COUNT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // number
   input  logic [1:0]  req_tuser,   // prefix_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // char_byte
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_wdata
);
   import dale_pkg::*;

   localparam int BCD_WIDTH = 4 * DIGIT_COUNT;

   logic                 append_crlf_ff;
   logic                 valid_s [DABBLE_STAGES+1];
   logic                 ready_s [DABBLE_STAGES+1];
   dale_word_type        word_s  [DABBLE_STAGES+1];
   logic [BCD_WIDTH-1:0] bcd_s   [DABBLE_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         append_crlf_ff <= 1'b1;
      end else if (csr_wen) begin
         append_crlf_ff <= csr_wdata;
      end
   end

   assign valid_s[0]       = req_tvalid;
   assign word_s[0].prefix = req_tuser;
   assign word_s[0].bin    = req_tdata;
   assign bcd_s[0]         = '0;
   assign req_tready       = ready_s[0];

   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_stage
      dale_bcd_stage #(
         .DIGIT_COUNT(DIGIT_COUNT)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_s[g]),
         .in_ready (ready_s[g]),
         .in_word  (word_s[g]),
         .in_bcd   (bcd_s[g]),
         .out_valid(valid_s[g+1]),
         .out_ready(ready_s[g+1]),
         .out_word (word_s[g+1]),
         .out_bcd  (bcd_s[g+1])
      );
   end

   dale_serializer #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_s[DABBLE_STAGES]),
      .in_ready  (ready_s[DABBLE_STAGES]),
      .in_prefix (word_s[DABBLE_STAGES].prefix),
      .in_bcd    (bcd_s[DABBLE_STAGES]),
      .crlf      (append_crlf_ff),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("Output valid right after reset.");

   a_lf_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == ASCII_LF |-> rsp_tlast)
      else $error("Line feed not flagged as the final byte.");

   a_cr_then_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata == ASCII_CR
      |=> rsp_tvalid && rsp_tdata == ASCII_LF)
      else $error("Carriage return not followed at once by line feed.");

endmodule

>>> tb/tb_top.sv
module tb_top;
   import dale_pkg::*;

   localparam logic [1:0] PREFIX_NONE_ALT = 2'd3;
   localparam int DEMO_ROWS    = 20;
   localparam int RANDOM_LINES = 84;
   localparam int DRAIN_SLACK  = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic        crlf;
      logic [1:0]  sel;
      logic [31:0] num;
   } demo_row_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } line_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // number
   logic [1:0]  req_tuser = '0;   // prefix_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // char_byte
   logic        rsp_tlast;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;

   line_byte_type expected_chars[$];
   logic crlf_setting = 1'b1;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req_count = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int error_count = 0;
   int lines_sent = 0;
   int bytes_checked = 0;
   int crlf_writes = 0;

   // Directed lines; an empty text means the expected run comes from the predictor.
   demo_row_type demo_rows [DEMO_ROWS] = '{
      '{1'b1, PREFIX_NONE,     32'd0},
      '{1'b1, PREFIX_NONE,     32'hffff_ffff},
      '{1'b1, PREFIX_MINUS,    32'hffff_ffff},
      '{1'b1, PREFIX_LETTER_C, 32'd0},
      '{1'b1, PREFIX_NONE_ALT, 32'd7},
      '{1'b1, PREFIX_MINUS,    32'd9},
      '{1'b1, PREFIX_NONE,     32'd10},
      '{1'b1, PREFIX_LETTER_C, 32'd1000000000},
      '{1'b1, PREFIX_NONE_ALT, 32'd999999999},
      '{1'b1, PREFIX_MINUS,    32'h5555_5555},
      '{1'b1, PREFIX_LETTER_C, 32'haaaa_aaaa},
      '{1'b0, PREFIX_NONE,     32'd0},
      '{1'b0, PREFIX_NONE_ALT, 32'd0},
      '{1'b0, PREFIX_MINUS,    32'hffff_ffff},
      '{1'b0, PREFIX_LETTER_C, 32'd1},
      '{1'b0, PREFIX_NONE,     32'h8000_0000},
      '{1'b0, PREFIX_NONE_ALT, 32'h5555_5555},
      '{1'b0, PREFIX_MINUS,    32'd99},
      '{1'b1, PREFIX_LETTER_C, 32'd5},
      '{1'b1, PREFIX_NONE,     32'd4000000000}
   };
   string demo_text [DEMO_ROWS] = '{
      "0", "4294967295", "-4294967295", "C0", "7", "-9", "10", "C1000000000",
      "999999999", "", "",
      "0", "0", "-4294967295", "C1", "2147483648", "", "-99",
      "C5", "4000000000"
   };

   decimal_ascii_line_emitter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void note_mismatch(input string what, input int expv, input int gotv);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("mismatch on %s: expected 'h%0h, got 'h%0h", what, expv, gotv);
      end
   endfunction

   // Closes a run of bytes: appends CR/LF when enabled and flags the final byte.
   function automatic void close_run(ref logic [7:0] text[$]);
      if (crlf_setting) begin
         text.push_back(ASCII_CR);
         text.push_back(ASCII_LF);
      end
      foreach (text[i]) begin
         expected_chars.push_back('{text[i], i == text.size() - 1});
      end
   endfunction

   function automatic void predict_line(input logic [31:0] num, input logic [1:0] sel);
      logic [7:0] text[$];
      logic [7:0] digits[$];
      logic [31:0] rest;
      rest = num;
      case (sel)
         PREFIX_MINUS: text.push_back(ASCII_MINUS);
         PREFIX_LETTER_C: text.push_back(ASCII_C);
         default: ;
      endcase
      do begin
         digits.push_front({ASCII_DIGIT_HI, 4'(rest % 32'd10)});
         rest = rest / 32'd10;
      end while (rest != 0);
      foreach (digits[i]) text.push_back(digits[i]);
      close_run(text);
   endfunction

   function automatic void expect_text(input string golden);
      logic [7:0] text[$];
      for (int i = 0; i < golden.len(); i++) text.push_back(golden[i]);
      close_run(text);
   endfunction

   function automatic logic [31:0] pick_number();
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned pow;
      int width;
      pow = 1;
      width = $urandom_range(1, 10);
      for (int i = 0; i < width; i++) pow = pow * 10;
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return ($urandom_range(0, 1) == 1) ? 32'(pow / 10) : 32'((pow > 64'hffff_ffff) ?
                   64'hffff_ffff : pow - 1);
         default: begin
            lo = (width == 1) ? 0 : pow / 10;
            hi = (pow - 1 > 64'hffff_ffff) ? 64'hffff_ffff : pow - 1;
            return 32'(lo + ({$urandom(), $urandom()} % (hi - lo + 1)));
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_req_count != hold_seen) begin
         hold_seen = hold_req_count;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      line_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (expected_chars.size() == 0) begin
            note_mismatch("unexpected transfer", 0, {rsp_tlast, rsp_tdata});
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.ch) note_mismatch("rsp_tdata", want.ch, rsp_tdata);
            if (rsp_tlast !== want.last) note_mismatch("rsp_tlast", want.last, rsp_tlast);
         end
      end
   end

   // Leaves req_tvalid high on return so that back-to-back transfers need no second write.
   task automatic send_line(input logic [31:0] num, input logic [1:0] sel,
                            input string golden);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= num;
      req_tuser <= sel;
      do @(posedge clock); while (!req_tready);
      if (golden.len() != 0) expect_text(golden);
      else predict_line(num, sel);
      lines_sent++;
   endtask

   task automatic drain_lines();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_crlf(input logic value);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      crlf_setting = value;
      crlf_writes++;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DEMO_ROWS; r++) begin
         if (demo_rows[r].crlf != crlf_setting) begin
            drain_lines();
            write_crlf(demo_rows[r].crlf);
         end
         send_line(demo_rows[r].num, demo_rows[r].sel, demo_text[r]);
      end

      for (int phase = 0; phase < 3; phase++) begin
         drain_lines();
         write_crlf(phase != 1);
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 32 : 0;
         for (int n = 0; n < RANDOM_LINES; n++) begin
            if (phase == 1 && n == 20) hold_req_count++;
            if (phase == 2 && n == RANDOM_LINES / 2) drain_lines();
            send_line(pick_number(), 2'($urandom_range(0, 3)), "");
         end
      end

      drain_lines();
      $display("Run covered %0d lines (%0d directed) and %0d checked byte transfers,",
               lines_sent, DEMO_ROWS, bytes_checked);
      $display("with %0d CR/LF register writes, random stalls on both sides and a long hold-off.",
               crlf_writes);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
